### sv/rnga_pkg.sv
// Shared constants and types of the ring neighbor grant arbiter.
`timescale 1ns / 1ps

package rnga_pkg;

   // Number of seat cells in the ring.
   localparam int MAX_SEATS = 16;
   // Width of a seat index.
   localparam int SEAT_W = 4;
   // Width of the seat count register.
   localparam int CNT_W = 5;
   // Seat count after reset.
   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(5);

   // Codes for the two input actions.
   localparam logic ACT_REQUEST = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      ST_THINKING = 2'd0,
      ST_HUNGRY   = 2'd1,
      ST_EATING   = 2'd2
   } seat_state_type;

   // Command broadcast from the sequencer to one seat cell.
   typedef struct packed {
      logic           write;     // load wr_state into the cell
      seat_state_type wr_state;  // state to load
      logic           test;      // run the grant test on this cell
   } cell_cmd_type;

endpackage

### sv/rnga_seat_cell.sv
// One seat of the ring: holds its state and runs the grant test.
`timescale 1ns / 1ps

module rnga_seat_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rnga_pkg::cell_cmd_type cmd,
   input  logic                  eat_left,
   input  logic                  eat_right,
   output logic                  eating,
   output logic                  grant
);

   rnga_pkg::seat_state_type state_ff;
   rnga_pkg::seat_state_type state_in;

   always_comb begin
      grant = cmd.test && (state_ff == rnga_pkg::ST_HUNGRY) && !eat_left && !eat_right;
      state_in = state_ff;
      if (cmd.write) begin
         state_in = cmd.wr_state;
      end else if (grant) begin
         state_in = rnga_pkg::ST_EATING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rnga_pkg::ST_THINKING;
      end else begin
         state_ff <= state_in;
      end
   end

   assign eating = (state_ff == rnga_pkg::ST_EATING);

endmodule

### sv/ring_neighbor_grant_arbiter_unit.sv
// Top level of the ring neighbor grant arbiter: sequencer, count register and seat ring.
`timescale 1ns / 1ps

// The block arbitrates a ring of seats in which each seat shares a resource with
// both of its neighbors. A request (req_action = 0) is taken at a clock edge where
// start is high and busy is low. A request marks the seat hungry and gives one
// result telling whether the seat was granted. A release (req_action = 1) marks the
// seat thinking and gives two results: the test of the left neighbor, then the test
// of the right neighbor, the second flagged by rsp_last. A seat at or above the
// active count gives one result with rsp_bad_seat set and changes nothing. Each
// result is shown for exactly one cycle under rsp_strobe and must be taken then;
// the receiver cannot stall the block. The seat state is written at the edge that
// takes the request; busy then stays high through the grant test phases, S_TEST1
// and, for a release, S_TEST2, and the result register lets the next request
// enter while the last result is still on the ports. The user must write the seat
// count through the csr_ port only while the block is idle; the block does not
// enforce this. Values above the number of seat cells are treated as that number.
module ring_neighbor_grant_arbiter_unit (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [rnga_pkg::SEAT_W-1:0]   req_seat,
   // Result channel.
   output logic                          rsp_strobe,
   output logic [rnga_pkg::SEAT_W-1:0]   rsp_tested_seat,
   output logic                          rsp_granted,
   output logic                          rsp_bad_seat,
   output logic                          rsp_last,
   // Seat count register.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rnga_pkg::CNT_W-1:0]    csr_data
);

   localparam logic [rnga_pkg::CNT_W-1:0] MAX_CNT = rnga_pkg::CNT_W'(rnga_pkg::MAX_SEATS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_TEST1,
      S_TEST2
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [rnga_pkg::CNT_W-1:0]      count_ff;
   logic [rnga_pkg::SEAT_W-1:0]     seat_ff, seat_in;
   logic [rnga_pkg::SEAT_W-1:0]     left_ff, left_in;
   logic [rnga_pkg::SEAT_W-1:0]     right_ff, right_in;
   logic                            action_ff, action_in;
   logic                            bad_ff, bad_in;
   logic                            strobe_in, granted_in, badout_in, last_in;
   logic [rnga_pkg::SEAT_W-1:0]     tested_in;

   logic [rnga_pkg::CNT_W-1:0]      n_eff;
   logic [rnga_pkg::SEAT_W-1:0]     last_idx;
   logic                            accept;
   logic                            req_bad;
   logic [rnga_pkg::SEAT_W-1:0]     req_left, req_right;
   logic [rnga_pkg::SEAT_W-1:0]     test_seat;
   logic                            test_en;

   logic [rnga_pkg::MAX_SEATS-1:0]  eating;
   logic [rnga_pkg::MAX_SEATS-1:0]  grants;
   logic [rnga_pkg::MAX_SEATS-1:0]  eat_l, eat_r;
   rnga_pkg::cell_cmd_type          cmds [rnga_pkg::MAX_SEATS];

   // The register always takes a write; software must write it only while idle, which the block does not check.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= rnga_pkg::COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_data;
      end
   end

   // Effective ring size and the index of the seat that closes the ring.
   assign n_eff    = (count_ff > MAX_CNT) ? MAX_CNT : count_ff;
   assign last_idx = rnga_pkg::SEAT_W'(n_eff - rnga_pkg::CNT_W'(1));

   assign busy    = (phase_ff != S_IDLE);
   assign accept  = start && !busy;
   assign req_bad = ({1'b0, req_seat} >= n_eff);

   // Ring neighbors of the incoming seat; with one seat both are the seat itself.
   assign req_left  = (req_seat == '0) ? last_idx : req_seat - rnga_pkg::SEAT_W'(1);
   assign req_right = (({1'b0, req_seat} + rnga_pkg::CNT_W'(1)) >= n_eff) ? '0
                    : req_seat + rnga_pkg::SEAT_W'(1);

   // The first test looks at the acting seat for a request and at its left
   // neighbor for a release; the second test is always the right neighbor.
   assign test_seat = (phase_ff == S_TEST1) ? (action_ff ? left_ff : seat_ff) : right_ff;
   assign test_en   = ((phase_ff == S_TEST1) && !bad_ff) || (phase_ff == S_TEST2);

   // Seat ring. Each cell hands its eating flag to both neighbors every cycle;
   // the cell that closes the ring hands it across to seat zero and back.
   for (genvar i = 0; i < rnga_pkg::MAX_SEATS; i++) begin : g_ring
      if (i == 0) begin : g_first
         assign eat_l[i] = eating[last_idx];
      end else begin : g_inner_l
         assign eat_l[i] = eating[i-1];
      end
      if (i == rnga_pkg::MAX_SEATS - 1) begin : g_end
         assign eat_r[i] = eating[0];
      end else begin : g_inner_r
         assign eat_r[i] = (last_idx == rnga_pkg::SEAT_W'(i)) ? eating[0] : eating[i+1];
      end

      assign cmds[i].write    = accept && !req_bad && (req_seat == rnga_pkg::SEAT_W'(i));
      assign cmds[i].wr_state = (req_action == rnga_pkg::ACT_RELEASE) ? rnga_pkg::ST_THINKING
                              : rnga_pkg::ST_HUNGRY;
      assign cmds[i].test     = test_en && (test_seat == rnga_pkg::SEAT_W'(i));

      rnga_seat_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmds[i]),
         .eat_left  (eat_l[i]),
         .eat_right (eat_r[i]),
         .eating    (eating[i]),
         .grant     (grants[i])
      );
   end

   // Sequencer next state and result register inputs.
   always_comb begin
      phase_in   = phase_ff;
      seat_in    = seat_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      action_in  = action_ff;
      bad_in     = bad_ff;
      strobe_in  = 1'b0;
      tested_in  = test_seat;
      granted_in = |grants;
      badout_in  = 1'b0;
      last_in    = 1'b0;
      case (phase_ff)
         S_IDLE: begin
            if (accept) begin
               seat_in   = req_seat;
               left_in   = req_left;
               right_in  = req_right;
               action_in = req_action;
               bad_in    = req_bad;
               phase_in  = S_TEST1;
            end
         end
         S_TEST1: begin
            strobe_in = 1'b1;
            if (bad_ff) begin
               tested_in  = seat_ff;
               granted_in = 1'b0;
               badout_in  = 1'b1;
               last_in    = 1'b1;
               phase_in   = S_IDLE;
            end else if (action_ff == rnga_pkg::ACT_RELEASE) begin
               phase_in = S_TEST2;
            end else begin
               last_in  = 1'b1;
               phase_in = S_IDLE;
            end
         end
         S_TEST2: begin
            strobe_in = 1'b1;
            last_in   = 1'b1;
            phase_in  = S_IDLE;
         end
         default: begin
            phase_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= S_IDLE;
         rsp_strobe <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         rsp_strobe <= strobe_in;
      end
      seat_ff         <= seat_in;
      left_ff         <= left_in;
      right_ff        <= right_in;
      action_ff       <= action_in;
      bad_ff          <= bad_in;
      rsp_tested_seat <= tested_in;
      rsp_granted     <= granted_in;
      rsp_bad_seat    <= badout_in;
      rsp_last        <= last_in;
   end

   // At most one seat is tested, and so granted, in any cycle.
   a_one_grant: assert property (@(posedge clock) disable iff (reset)
      $onehot0(grants))
      else $error("more than one seat granted in one cycle");

   // A taken request always yields a result, registered from its first test phase.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("no result after a taken request");

   // An out of range seat gives a lone result that grants nothing.
   a_bad_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_bad_seat) |-> (rsp_last && !rsp_granted))
      else $error("bad seat result not final or granted");

   // The second result of a release comes right after the first.
   a_release_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> (rsp_strobe && rsp_last))
      else $error("release result pair broken");

endmodule
